/* hw/rtl/hct_pkg.sv */
// Shared types and constants for the Huffman code tree builder.
package hct_pkg;

    localparam int MAX_SYMBOLS_DEF  = 4096;
    localparam int MAX_CODE_LEN_DEF = 40;

    localparam int COUNT_IN_W = 32;
    localparam int COUNT_W    = 50;
    localparam int INDEX_W    = 12;
    localparam int DEPTH_W    = 6;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_QUERY = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_INDEX  = 2'd1,
        ST_TOO_LONG   = 2'd2,
        ST_BUILD_DONE = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_B_LEAF,
        S_B_INNER,
        S_B_PICK,
        S_B_WRITE,
        S_Q_READ,
        S_Q_LINK,
        S_E_READ,
        S_E_OUT
    } state_t;

    typedef struct packed {
        op_t                   op;
        logic [COUNT_IN_W-1:0] word_count;
        logic [INDEX_W-1:0]    word_index;
    } req_t;

    typedef struct packed {
        logic               code_bit;
        logic [INDEX_W-1:0] inner_node;
        logic [DEPTH_W-1:0] depth;
        logic               last;
        status_t            status;
    } rsp_t;

endpackage

/* hw/rtl/huffman_code_tree_builder.sv */
// Huffman code tree builder: two-queue merge over counts, codeword walk per query.
//
//   channel   handshake               payload   notes
//   request   start & !busy           request   load, build, query, clear
//   result    strobe (one cycle)      result    no backpressure
//
// Load and clear give no result. A build runs n - 1 merges, each picking the smaller of the
// next leaf and inner counts twice (leaf read, inner read, pick) and then writing the sum,
// bounded by the single read port of the count memory, then gives one done result. A query
// walks parents one tree level at a time (read, link), then reads back the path buffer
// (read, out), one result per level. Bad-index and not-built errors are reported the
// cycle after the request; a too-long code after all MAX_CODE_LEN levels have been walked.
// Reset empties the symbol store and invalidates the tree; memories are not cleared.
module huffman_code_tree_builder
    import hct_pkg::*;
#(
    parameter int MAX_SYMBOLS  = MAX_SYMBOLS_DEF,
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic strobe,
    output rsp_t result
);

    localparam int SYM_CW  = $clog2(MAX_SYMBOLS + 1);
    localparam int SYM_CW1 = SYM_CW + 1;
    localparam int NODE_AW = $clog2(2 * MAX_SYMBOLS);
    localparam int LINK_W  = NODE_AW + 1;
    localparam int PATH_W  = INDEX_W + 1;
    localparam int LEN_W   = $clog2(MAX_CODE_LEN + 1);
    localparam int PB_AW   = $clog2(MAX_CODE_LEN);

    state_t               state_reg, state_next;
    logic [SYM_CW-1:0]    sym_cnt_reg, sym_cnt_next;
    logic                 built_reg, built_next;
    logic [SYM_CW-1:0]    leaf_rem_reg, leaf_rem_next;
    logic [NODE_AW-1:0]   inner_pos_reg, inner_pos_next;
    logic [NODE_AW-1:0]   made_reg, made_next;
    logic                 pick_sel_reg, pick_sel_next;
    logic [COUNT_W-1:0]   first_val_reg, first_val_next;
    logic [COUNT_W-1:0]   leaf_val_reg, leaf_val_next;
    logic [NODE_AW-1:0]   node_reg, node_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [LEN_W-1:0]     depth_reg, depth_next;
    logic                 strobe_reg, strobe_next;
    rsp_t                 result_reg, result_next;

    logic                 cnt_we;
    logic [NODE_AW-1:0]   cnt_waddr, cnt_raddr;
    logic [COUNT_W-1:0]   cnt_wdata, cnt_rdata;
    logic                 link_we;
    logic [NODE_AW-1:0]   link_waddr;
    logic [LINK_W-1:0]    link_wdata, link_rdata;
    logic                 path_we;
    logic [PB_AW-1:0]     path_waddr, path_raddr;
    logic [PATH_W-1:0]    path_wdata, path_rdata;

    logic                 accept;
    logic [NODE_AW-1:0]   root;
    logic [NODE_AW-1:0]   n_node;
    logic                 leaf_ok, inner_ok, take_leaf;
    logic [NODE_AW-1:0]   pick_idx;
    logic [COUNT_W-1:0]   pick_val;
    logic [COUNT_W:0]     sum_wide;
    logic [COUNT_W-1:0]   sum_sat;
    logic [NODE_AW-1:0]   link_parent;
    logic                 index_bad;

    hct_ram #(.WIDTH(COUNT_W), .DEPTH(2 * MAX_SYMBOLS)) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    hct_ram #(.WIDTH(LINK_W), .DEPTH(2 * MAX_SYMBOLS)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (node_reg),
        .rdata (link_rdata)
    );

    hct_ram #(.WIDTH(PATH_W), .DEPTH(MAX_CODE_LEN)) u_path_ram (
        .clk   (clk),
        .we    (path_we),
        .waddr (path_waddr),
        .wdata (path_wdata),
        .raddr (path_raddr),
        .rdata (path_rdata)
    );

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;
    assign accept = start && !busy;

    assign n_node      = NODE_AW'(sym_cnt_reg);
    assign root        = NODE_AW'({sym_cnt_reg, 1'b0} - SYM_CW1'(2));
    assign leaf_ok     = (leaf_rem_reg != '0);
    assign inner_ok    = (inner_pos_reg < made_reg);
    assign take_leaf   = leaf_ok && (!inner_ok || (leaf_val_reg < cnt_rdata));
    assign pick_idx    = take_leaf ? NODE_AW'(leaf_rem_reg - SYM_CW'(1)) : inner_pos_reg;
    assign pick_val    = take_leaf ? leaf_val_reg : cnt_rdata;
    assign sum_wide    = {1'b0, first_val_reg} + {1'b0, leaf_val_reg};
    assign sum_sat     = sum_wide[COUNT_W] ? '1 : sum_wide[COUNT_W-1:0];
    assign link_parent = link_rdata[NODE_AW-1:0];
    assign index_bad   = ({{SYM_CW{1'b0}}, request.word_index}
                          >= {{INDEX_W{1'b0}}, sym_cnt_reg});

    always_comb
    begin
        state_next     = state_reg;
        sym_cnt_next   = sym_cnt_reg;
        built_next     = built_reg;
        leaf_rem_next  = leaf_rem_reg;
        inner_pos_next = inner_pos_reg;
        made_next      = made_reg;
        pick_sel_next  = pick_sel_reg;
        first_val_next = first_val_reg;
        leaf_val_next  = leaf_val_reg;
        node_next      = node_reg;
        len_next       = len_reg;
        depth_next     = depth_reg;
        strobe_next    = 1'b0;
        result_next    = result_reg;

        cnt_we     = 1'b0;
        cnt_waddr  = made_reg;
        cnt_wdata  = sum_sat;
        cnt_raddr  = inner_pos_reg;
        link_we    = 1'b0;
        link_waddr = pick_idx;
        link_wdata = {pick_sel_reg, made_reg};
        path_we    = 1'b0;
        path_waddr = PB_AW'(len_reg);
        path_wdata = {link_rdata[NODE_AW], INDEX_W'(link_parent - n_node)};
        path_raddr = PB_AW'(len_reg - LEN_W'(1) - depth_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (request.op)
                        OP_LOAD:
                        begin
                            if (sym_cnt_reg < SYM_CW'(MAX_SYMBOLS))
                            begin
                                cnt_we       = 1'b1;
                                cnt_waddr    = n_node;
                                cnt_wdata    = COUNT_W'(request.word_count);
                                sym_cnt_next = sym_cnt_reg + SYM_CW'(1);
                                built_next   = 1'b0;
                            end
                        end
                        OP_BUILD:
                        begin
                            built_next = 1'b0;
                            if (sym_cnt_reg < SYM_CW'(2))
                            begin
                                strobe_next        = 1'b1;
                                result_next        = '0;
                                result_next.last   = 1'b1;
                                result_next.status = ST_BUILD_DONE;
                            end
                            else
                            begin
                                leaf_rem_next  = sym_cnt_reg;
                                inner_pos_next = n_node;
                                made_next      = n_node;
                                pick_sel_next  = 1'b0;
                                state_next     = S_B_LEAF;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (!built_reg || index_bad)
                            begin
                                strobe_next        = 1'b1;
                                result_next        = '0;
                                result_next.last   = 1'b1;
                                result_next.status = ST_BAD_INDEX;
                            end
                            else
                            begin
                                node_next  = NODE_AW'(request.word_index);
                                len_next   = '0;
                                state_next = S_Q_READ;
                            end
                        end
                        OP_CLEAR:
                        begin
                            sym_cnt_next = '0;
                            built_next   = 1'b0;
                        end
                        default:
                        begin
                            built_next = built_reg;
                        end
                    endcase
                end
            end
            S_B_LEAF:
            begin
                cnt_raddr  = NODE_AW'(leaf_rem_reg - SYM_CW'(1));
                state_next = S_B_INNER;
            end
            S_B_INNER:
            begin
                cnt_raddr     = inner_pos_reg;
                leaf_val_next = cnt_rdata;
                state_next    = S_B_PICK;
            end
            S_B_PICK:
            begin
                link_we = 1'b1;
                if (take_leaf)
                begin
                    leaf_rem_next = leaf_rem_reg - SYM_CW'(1);
                end
                else
                begin
                    inner_pos_next = inner_pos_reg + NODE_AW'(1);
                end
                if (!pick_sel_reg)
                begin
                    first_val_next = pick_val;
                    pick_sel_next  = 1'b1;
                    state_next     = S_B_LEAF;
                end
                else
                begin
                    leaf_val_next = pick_val;
                    pick_sel_next = 1'b0;
                    state_next    = S_B_WRITE;
                end
            end
            S_B_WRITE:
            begin
                cnt_we = 1'b1;
                if (made_reg == root)
                begin
                    built_next         = 1'b1;
                    strobe_next        = 1'b1;
                    result_next        = '0;
                    result_next.last   = 1'b1;
                    result_next.status = ST_BUILD_DONE;
                    state_next         = S_IDLE;
                end
                else
                begin
                    made_next  = made_reg + NODE_AW'(1);
                    state_next = S_B_LEAF;
                end
            end
            S_Q_READ:
            begin
                if (len_reg == LEN_W'(MAX_CODE_LEN))
                begin
                    strobe_next        = 1'b1;
                    result_next        = '0;
                    result_next.last   = 1'b1;
                    result_next.status = ST_TOO_LONG;
                    state_next         = S_IDLE;
                end
                else
                begin
                    state_next = S_Q_LINK;
                end
            end
            S_Q_LINK:
            begin
                path_we   = 1'b1;
                len_next  = len_reg + LEN_W'(1);
                node_next = link_parent;
                if (link_parent == root)
                begin
                    depth_next = '0;
                    state_next = S_E_READ;
                end
                else
                begin
                    state_next = S_Q_READ;
                end
            end
            S_E_READ:
            begin
                state_next = S_E_OUT;
            end
            S_E_OUT:
            begin
                strobe_next            = 1'b1;
                result_next.code_bit   = path_rdata[PATH_W-1];
                result_next.inner_node = path_rdata[INDEX_W-1:0];
                result_next.depth      = DEPTH_W'(depth_reg);
                result_next.last       = (LEN_W'(depth_reg + LEN_W'(1)) == len_reg);
                result_next.status     = ST_OK;
                if (result_next.last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    depth_next = depth_reg + LEN_W'(1);
                    state_next = S_E_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            sym_cnt_reg  <= '0;
            built_reg    <= 1'b0;
            pick_sel_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sym_cnt_reg  <= sym_cnt_next;
            built_reg    <= built_next;
            pick_sel_reg <= pick_sel_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        leaf_rem_reg  <= leaf_rem_next;
        inner_pos_reg <= inner_pos_next;
        made_reg      <= made_next;
        first_val_reg <= first_val_next;
        leaf_val_reg  <= leaf_val_next;
        node_reg      <= node_next;
        len_reg       <= len_next;
        depth_reg     <= depth_next;
        result_reg    <= result_next;
    end

endmodule

/* hw/rtl/hct_ram.sv */
// Generic one-write, one-read RAM with registered read data.
module hct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
